// ===== rtl/core/bnge_pkg.sv =====
// Shared types, constants and root table for the band gate/expander.
package bnge_pkg;

    typedef struct packed {
        logic               gate_enable;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic signed [15:0] threshold_db;
        logic [15:0]        expander_slope;
        logic signed [15:0] makeup_db;
    } t_cfg;

    localparam logic [2:0] REG_GATE_ENABLE    = 3'd0;
    localparam logic [2:0] REG_ATTACK_COEFF   = 3'd1;
    localparam logic [2:0] REG_RELEASE_COEFF  = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_DB   = 3'd3;
    localparam logic [2:0] REG_EXPANDER_SLOPE = 3'd4;
    localparam logic [2:0] REG_MAKEUP_DB      = 3'd5;

    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd10240;
    localparam logic [15:0]         SLOPE_RESET     = 16'd32768;

    localparam int SILENCE_DB_Q88    = -30720;
    localparam int GATE_FLOOR_Q88    = 20480;
    localparam int DB_PER_OCTAVE_Q16 = 394566;
    localparam int OCTAVE_PER_DB_Q16 = 10885;
    localparam int RISE_12DB_Q20     = 4174456;
    localparam int UNITY_Q12         = 4096;

    typedef logic [15:0][31:0] t_root_tab;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30 for k = 1..16, by repeated square roots
    function automatic t_root_tab f_root_tab();
        t_root_tab   t;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            r = f_isqrt(r << 30);
            t[k] = r[31:0];
        end
        return t;
    endfunction

    localparam t_root_tab ROOT_Q30 = f_root_tab();

endpackage

// ===== rtl/core/band_noise_gate_expander.sv =====
// Top level of one gate/expander band: config registers, front, queue, back.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample_in
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: sample_out, gain_linear;
//                                                tuser: transient_seen
//  cfg       in   i_cfg_wr_en (no wait)          i_cfg_addr, i_cfg_wr_data
//
// The front end takes a new sample only after its last one is in the queue
// (envelope multiplies, rise test). With the gate on, the back end runs a
// byte/bit leading-zero walk, 16 squaring steps for log2 and 16 multiply
// steps for the gain exponent, one multiply per step; a zero envelope skips
// the walk and log2, the gate off skips it all; that sets the sustained rate.
// A two-beat queue lets the front run ahead; the output register lets the back
// finish its next sample while a result waits. Reset is synchronous, active low.
module band_noise_gate_expander #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_in, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, [+15:+0] gain_linear above it, rest zero
    output logic [((SAMPLE_BITS+23)/8)*8-1:0]      m_axis_tdata,
    // [0] transient_seen
    output logic                                   m_axis_tuser,
    input  logic                                   i_cfg_wr_en,
    input  logic [2:0]                             i_cfg_addr,
    input  logic [15:0]                            i_cfg_wr_data
);
    localparam int SB    = SAMPLE_BITS;
    localparam int OUT_W = ((SAMPLE_BITS + 23) / 8) * 8;

    bnge_pkg::t_cfg      r_cfg;
    logic                q_push, q_full, q_pop, q_valid;
    logic [2*SB:0]       f_item, q_item;
    logic [SB-1:0]       b_sample;
    logic [15:0]         b_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable    <= 1'b0;
            r_cfg.attack_coeff   <= 16'd0;
            r_cfg.release_coeff  <= 16'd0;
            r_cfg.threshold_db   <= bnge_pkg::THRESHOLD_RESET;
            r_cfg.expander_slope <= bnge_pkg::SLOPE_RESET;
            r_cfg.makeup_db      <= 16'sd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bnge_pkg::REG_GATE_ENABLE:    r_cfg.gate_enable    <= i_cfg_wr_data[0];
                bnge_pkg::REG_ATTACK_COEFF:   r_cfg.attack_coeff   <= i_cfg_wr_data;
                bnge_pkg::REG_RELEASE_COEFF:  r_cfg.release_coeff  <= i_cfg_wr_data;
                bnge_pkg::REG_THRESHOLD_DB:   r_cfg.threshold_db   <= $signed(i_cfg_wr_data);
                bnge_pkg::REG_EXPANDER_SLOPE: r_cfg.expander_slope <= i_cfg_wr_data;
                bnge_pkg::REG_MAKEUP_DB:      r_cfg.makeup_db      <= $signed(i_cfg_wr_data);
                default: ;
            endcase
        end
    end

    bnge_front #(.SAMPLE_BITS(SB)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[SB-1:0]),
        .o_push  (q_push),
        .i_full  (q_full),
        .o_item  (f_item)
    );

    bnge_queue #(.WIDTH(2*SB+1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    bnge_back #(.SAMPLE_BITS(SB)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_sample  (b_sample),
        .o_gain    (b_gain),
        .o_trans   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({b_gain, b_sample});

endmodule

// ===== rtl/core/bnge_front.sv =====
// Front end: takes a sample, updates the peak envelope and the transient flag.
module bnge_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bnge_pkg::t_cfg           i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SAMPLE_BITS-1:0]   i_data,
    output logic                     o_push,
    input  logic                     i_full,
    output logic [2*SAMPLE_BITS:0]   o_item
);
    localparam int SB = SAMPLE_BITS;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MIX  = 2'd1;
    localparam logic [1:0] F_ENV  = 2'd2;
    localparam logic [1:0] F_TRN  = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [SB-1:0]  r_x, r_mag, r_env, r_old;
    logic [15:0]    r_c;
    logic [SB+15:0] r_acc;

    logic [SB-1:0]  mag_in;
    logic [15:0]    c_in;
    logic [SB+16:0] mix;
    logic [SB+17:0] sum;
    logic           trans;

    assign mag_in = i_data[SB-1] ? SB'(-i_data) : i_data;
    assign c_in   = (mag_in > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign mix    = (SB+17)'(17'd65536 - {1'b0, r_c}) * (SB+17)'(r_mag);
    assign sum    = (SB+18)'(r_acc) + (SB+18)'(mix) + (SB+18)'(32768);

    always_comb begin
        if (r_old == '0) begin
            trans = ((SB+7)'(r_env) * (SB+7)'(100)) > ((SB+7)'(1) << (SB-1));
        end else begin
            trans = ((SB+22)'(r_env) << 20) >
                    ((SB+22)'(r_old) * (SB+22)'(bnge_pkg::RISE_12DB_Q20));
        end
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_TRN) && !i_full;
    assign o_item  = {trans, r_env, r_x};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_MIX;
            F_MIX:  n_state = F_ENV;
            F_ENV:  n_state = F_TRN;
            F_TRN:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_ENV) begin
                r_env <= sum[SB+15:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_x   <= i_data;
            r_mag <= mag_in;
            r_c   <= c_in;
        end
        if (r_state == F_MIX) begin
            r_acc <= (SB+16)'(r_c) * (SB+16)'(r_env);
        end
        if (r_state == F_ENV) begin
            r_old <= r_env;
        end
    end

endmodule

// ===== rtl/core/bnge_queue.sv =====
// Two-entry queue between the envelope front end and the gain back end.
module bnge_queue #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/bnge_back.sv =====
// Back end: envelope to dB, gate curve, dB to linear gain, sample scaling.
module bnge_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bnge_pkg::t_cfg           i_cfg,
    input  logic                     i_q_valid,
    output logic                     o_q_pop,
    input  logic [2*SAMPLE_BITS:0]   i_q_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SAMPLE_BITS-1:0]   o_sample,
    output logic [15:0]              o_gain,
    output logic                     o_trans
);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = $clog2(SB);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_NORM  = 4'd1;
    localparam logic [3:0] B_SQR   = 4'd2;
    localparam logic [3:0] B_DB    = 4'd3;
    localparam logic [3:0] B_CMP   = 4'd4;
    localparam logic [3:0] B_DEPTH = 4'd5;
    localparam logic [3:0] B_EXPO  = 4'd6;
    localparam logic [3:0] B_MANT  = 4'd7;
    localparam logic [3:0] B_SCALE = 4'd8;
    localparam logic [3:0] B_OUT   = 4'd9;

    localparam logic signed [6:0]     FS_POS = 7'(SB - 1);
    localparam logic signed [SB+16:0] Y_HI = {18'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB+16:0] Y_LO = {{18{1'b1}}, {(SB-1){1'b0}}};

    logic [3:0]          r_state, n_state;
    logic [SB-1:0]       r_x, r_norm;
    logic                r_trans;
    logic [PW-1:0]       r_p;
    logic [31:0]         r_m, r_mant;
    logic [15:0]         r_frac, r_f, r_gain;
    logic [3:0]          r_cnt;
    logic signed [19:0]  r_edb, r_gdb;
    logic signed [43:0]  r_prod;
    logic signed [11:0]  r_ip;
    logic                r_ovalid, r_otrans;
    logic [SB-1:0]       r_osample;
    logic [15:0]         r_ogain;

    logic                out_free;
    logic [61:0]         sq;
    logic [31:0]         sq_t;
    logic signed [6:0]   pd;
    logic signed [43:0]  db_prod;
    logic signed [19:0]  thr20;
    logic [19:0]         diff;
    logic [43:0]         qs;
    logic [27:0]         q;
    logic [15:0]         dep;
    logic signed [35:0]  ep;
    logic [63:0]         mp;
    logic signed [11:0]  sh;
    logic [32:0]         rnd;
    logic [32:0]         g;
    logic [15:0]         gain_n;
    logic signed [SB+16:0] yp, ys;
    logic [SB-1:0]       y_sat;

    assign out_free = !r_ovalid || i_ready;
    assign o_q_pop  = (r_state == B_IDLE) && i_q_valid;

    assign sq      = 62'(r_m[30:0]) * 62'(r_m[30:0]);
    assign sq_t    = sq[61:30];
    assign pd      = $signed(7'(r_p)) - FS_POS;
    assign db_prod = 44'($signed({pd, r_frac})) * 44'(bnge_pkg::DB_PER_OCTAVE_Q16);
    assign thr20   = 20'(i_cfg.threshold_db);
    assign diff    = 20'(thr20 - r_edb);
    assign qs      = $unsigned(r_prod) + 44'd32768;
    assign q       = qs[43:16];
    assign dep     = (q > 28'(bnge_pkg::GATE_FLOOR_Q88)) ? 16'(bnge_pkg::GATE_FLOOR_Q88)
                                                          : q[15:0];
    assign ep      = 36'(r_gdb) * 36'(bnge_pkg::OCTAVE_PER_DB_Q16) + 36'sd128;
    assign mp      = 64'(r_mant) * 64'(bnge_pkg::ROOT_Q30[r_cnt]) + 64'd536870912;
    assign sh      = 12'sd18 - r_ip;
    assign rnd     = 33'(r_mant) + (33'd1 << (sh[4:0] - 5'd1));
    assign g       = rnd >> sh[4:0];

    always_comb begin
        if (r_ip >= 12'sd4) begin
            gain_n = 16'hFFFF;
        end else if (sh >= 12'sd32) begin
            gain_n = 16'd0;
        end else if (g > 33'd65535) begin
            gain_n = 16'hFFFF;
        end else begin
            gain_n = g[15:0];
        end
    end

    assign yp = (SB+17)'($signed(r_x)) * (SB+17)'($signed({1'b0, r_gain}))
              + (SB+17)'(2048);
    assign ys = yp >>> 12;

    always_comb begin
        if (ys > Y_HI) begin
            y_sat = Y_HI[SB-1:0];
        end else if (ys < Y_LO) begin
            y_sat = Y_LO[SB-1:0];
        end else begin
            y_sat = ys[SB-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    if (!i_cfg.gate_enable)           n_state = B_OUT;
                    else if (i_q_item[2*SB-1:SB] == '0) n_state = B_CMP;
                    else                               n_state = B_NORM;
                end
            end
            B_NORM:  if (r_norm[SB-1]) n_state = B_SQR;
            B_SQR:   if (r_cnt == 4'd15) n_state = B_DB;
            B_DB:    n_state = B_CMP;
            B_CMP:   n_state = (r_edb >= thr20) ? B_EXPO : B_DEPTH;
            B_DEPTH: n_state = B_EXPO;
            B_EXPO:  n_state = B_MANT;
            B_MANT:  if (r_cnt == 4'd15) n_state = B_SCALE;
            B_SCALE: n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_x     <= i_q_item[SB-1:0];
                r_norm  <= i_q_item[2*SB-1:SB];
                r_trans <= i_q_item[2*SB];
                r_p     <= PW'(SB - 1);
                r_gain  <= 16'(bnge_pkg::UNITY_Q12);
                r_edb   <= 20'(bnge_pkg::SILENCE_DB_Q88);
            end
            B_NORM: begin
                // skip a byte of leading zeros at a time, then single bits
                if (r_norm[SB-1 -: 8] == 8'd0) begin
                    r_norm <= r_norm << 8;
                    r_p    <= r_p - PW'(8);
                end else if (!r_norm[SB-1]) begin
                    r_norm <= r_norm << 1;
                    r_p    <= r_p - PW'(1);
                end
                r_m    <= {1'b0, 31'({r_norm, 31'b0} >> SB)};
                r_frac <= 16'd0;
                r_cnt  <= 4'd0;
            end
            B_SQR: begin
                if (sq_t[31]) begin
                    r_m    <= {1'b0, sq_t[31:1]};
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= sq_t;
                    r_frac <= {r_frac[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
            end
            B_DB: begin
                r_edb <= 20'((db_prod + 44'sd8388608) >>> 24);
            end
            B_CMP: begin
                r_gdb  <= 20'(i_cfg.makeup_db);
                r_prod <= 44'(diff) * 44'(i_cfg.expander_slope);
            end
            B_DEPTH: begin
                r_gdb <= 20'(i_cfg.makeup_db) - $signed(20'(dep));
            end
            B_EXPO: begin
                r_ip   <= 12'(ep >>> 24);
                r_f    <= ep[23:8];
                r_mant <= 32'd1 << 30;
                r_cnt  <= 4'd0;
            end
            B_MANT: begin
                if (r_f[15]) begin
                    r_mant <= mp[61:30];
                end
                r_f   <= r_f << 1;
                r_cnt <= r_cnt + 4'd1;
            end
            B_SCALE: begin
                r_gain <= gain_n;
            end
            B_OUT: begin
                if (out_free) begin
                    r_osample <= y_sat;
                    r_ogain   <= r_gain;
                    r_otrans  <= r_trans;
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_sample = r_osample;
    assign o_gain   = r_ogain;
    assign o_trans  = r_otrans;

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_NORM) |-> (r_norm != '0))
        else $error("normalizer running on a zero envelope");

    a_sqr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SQR) |-> !r_m[31])
        else $error("log2 mantissa out of range");

    a_level_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CMP) |-> (r_edb <= 20'sd0))
        else $error("envelope level above full scale");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != B_IDLE))
        else $error("back end took an item but stayed idle");

endmodule
